>>> hw/rtl/plob_pkg.sv
// types and constants shared by the order book front end, queue and matching back end
// no dependencies

package plob_pkg;

    localparam logic [1:0] OPC_ADD     = 2'd0;
    localparam logic [1:0] OPC_CANCEL  = 2'd1;
    localparam logic [1:0] OPC_CONSUME = 2'd2;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FILL   = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        side;
        logic [31:0] ord_id;
        logic [7:0]  price;
        logic [31:0] quantity;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [31:0] buy_id;
        logic [31:0] sell_id;
        logic [7:0]  fill_price;
        logic [31:0] fill_quantity;
        logic [31:0] leftover;
        logic        lvl_empty;
        logic        last;
    } t_result;

    typedef enum logic [1:0] {
        JOB_ADD,
        JOB_CANCEL,
        JOB_CONSUME
    } t_job_op;

    typedef struct packed {
        t_job_op     op;
        logic        price_ok;
        logic        side;
        logic [31:0] ord_id;
        logic [7:0]  price;
        logic [31:0] quantity;
    } t_job;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_SRCH,
        B_ALLOC_RD,
        B_ADD_WR,
        B_REL_RD,
        B_REL_LV,
        B_REL_DO,
        B_C_HD,
        B_C_CHK,
        B_C_FILL
    } t_bstate;

endpackage

>>> hw/rtl/plob_front.sv
// command front end: takes a command beat, classifies it and hands it to the job queue
// depends on plob_pkg

module plob_front import plob_pkg::*; #(
    parameter int PRICE_TICKS = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    input  logic i_full,
    output logic o_push,
    output t_job o_job
);

    logic r_vld, n_vld;
    t_job r_job, n_job;
    logic acc;

    assign busy   = r_vld & i_full;
    assign acc    = start & ~busy;
    assign o_push = r_vld & ~i_full;
    assign o_job  = r_job;

    always_comb begin
        n_vld = r_vld & ~o_push;
        n_job = r_job;
        if (acc) begin
            n_job.price_ok = (32'(i_cmd.price) < 32'(PRICE_TICKS));
            n_job.side     = i_cmd.side;
            n_job.ord_id   = i_cmd.ord_id;
            n_job.price    = i_cmd.price;
            n_job.quantity = i_cmd.quantity;
            n_job.op       = JOB_ADD;
            // unknown opcodes are dropped here
            unique case (i_cmd.opcode)
                OPC_ADD: begin
                    n_job.op = JOB_ADD;
                    n_vld    = 1'b1;
                end
                OPC_CANCEL: begin
                    n_job.op = JOB_CANCEL;
                    n_vld    = 1'b1;
                end
                OPC_CONSUME: begin
                    n_job.op = JOB_CONSUME;
                    n_vld    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_job <= n_job;
    end

endmodule

>>> hw/rtl/plob_fifo.sv
// short job queue between front end and back end
// depends on plob_pkg

module plob_fifo import plob_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_vld,
    output t_job o_job
);

    localparam int PW = $clog2(QDEPTH);

    t_job r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full = (r_cnt == (PW+1)'(QDEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_job  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> hw/rtl/plob_back.sv
// matching back end: slot store, per-level linked lists, free stack and the job sequencer
// depends on plob_pkg

module plob_back import plob_pkg::*; #(
    parameter int MAX_ORDERS        = 1024,
    parameter int PRICE_TICKS       = 256,
    parameter int FILLS_PER_CONSUME = 63
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_vld,
    input  t_job    i_job,
    output logic    o_pop,
    output t_result o_res,
    output logic    o_stb
);

    localparam int AW = $clog2(MAX_ORDERS);
    localparam int LV = 2 * PRICE_TICKS;
    localparam int LW = $clog2(LV);
    localparam int CN = (MAX_ORDERS > LV) ? MAX_ORDERS : LV;
    localparam int CW = $clog2(CN);
    localparam logic [AW:0] NIL = (AW+1)'(MAX_ORDERS);

    // storage
    logic [31:0] m_id    [MAX_ORDERS];
    logic [31:0] m_rem   [MAX_ORDERS];
    logic [LW-1:0] m_place [MAX_ORDERS];
    logic [AW-1:0] m_next  [MAX_ORDERS];
    logic [AW-1:0] m_prev  [MAX_ORDERS];
    logic        m_valid [MAX_ORDERS];
    logic [AW:0] m_head  [LV];
    logic [AW:0] m_tail  [LV];
    logic [AW-1:0] m_stk   [MAX_ORDERS];

    logic [31:0] d_id, d_rem;
    logic [LW-1:0] d_place;
    logic [AW-1:0] d_next, d_prev, d_stk;
    logic        d_valid;
    logic [AW:0] d_head, d_tail;

    // memory controls
    logic [AW-1:0] slot_ra, stk_ra, w_slot, w_valid, w_next, w_prev, w_stk;
    logic [LW-1:0] lvl_ra, w_lvl;
    logic we_id, we_rem, we_place, we_valid, we_next, we_prev, we_head, we_tail, we_stk;
    logic [31:0] wd_rem;
    logic        wd_valid;
    logic [AW-1:0] wd_next, wd_prev, wd_stk;
    logic [AW:0] wd_head, wd_tail;

    // sequencer registers
    t_bstate r_state, n_state;
    logic [CW-1:0] r_clr, n_clr;
    logic [AW:0]   r_fc, n_fc, r_lo, n_lo;
    logic          r_fromstk, n_fromstk;
    t_job          r_job, n_job;
    logic [LW-1:0] r_lvl, n_lvl, r_plc, n_plc;
    logic [AW:0]   r_idx, n_idx;
    logic [AW-1:0] r_cidx, n_cidx, r_s, n_s, r_nx, n_nx, r_pv, n_pv;
    logic          r_chk, n_chk, r_ret, n_ret;
    logic [31:0]   r_qty, n_qty;
    logic [5:0]    r_k, n_k;
    t_result       r_res, n_res;
    logic          r_stb, n_stb;

    logic hit, miss, stop, zero;
    logic [31:0] fill;
    logic [AW-1:0] new_s;
    logic [LW-1:0] job_lvl;

    assign hit  = r_chk && d_valid && (d_id == r_job.ord_id);
    assign miss = r_chk && !hit && (r_cidx == AW'(MAX_ORDERS - 1));
    assign stop = (r_qty == '0) || (d_head == NIL) || (r_k == 6'(FILLS_PER_CONSUME));
    assign fill = (r_qty < d_rem) ? r_qty : d_rem;
    assign zero = (d_rem <= r_qty);
    assign new_s = r_fromstk ? d_stk : (AW'(MAX_ORDERS - 1) - r_fc[AW-1:0]);
    // consume walks the opposite side of the incoming order
    assign job_lvl = ((i_job.op == JOB_CONSUME) ? ~i_job.side : i_job.side)
                     ? (LW'(PRICE_TICKS) + LW'(i_job.price)) : LW'(i_job.price);

    assign o_res = r_res;
    assign o_stb = r_stb;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr == CW'(CN - 1)) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (i_job_vld) begin
                    unique case (i_job.op)
                        JOB_ADD:     n_state = (!i_job.price_ok || r_fc == '0) ? B_IDLE : B_SRCH;
                        JOB_CANCEL:  n_state = B_SRCH;
                        JOB_CONSUME: n_state = i_job.price_ok ? B_C_HD : B_IDLE;
                        default:     n_state = B_IDLE;
                    endcase
                end
            end
            B_SRCH: begin
                if (hit) begin
                    n_state = (r_job.op == JOB_ADD) ? B_IDLE : B_REL_RD;
                end else if (miss) begin
                    n_state = (r_job.op == JOB_ADD) ? B_ALLOC_RD : B_IDLE;
                end
            end
            B_ALLOC_RD: n_state = B_ADD_WR;
            B_ADD_WR:   n_state = B_IDLE;
            B_REL_RD:   n_state = B_REL_LV;
            B_REL_LV:   n_state = B_REL_DO;
            B_REL_DO:   n_state = r_ret ? B_C_HD : B_IDLE;
            B_C_HD:     n_state = B_C_CHK;
            B_C_CHK:    n_state = stop ? B_IDLE : B_C_FILL;
            B_C_FILL:   n_state = zero ? B_REL_RD : B_C_HD;
            default:    n_state = B_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        o_pop = 1'b0;
        n_clr = r_clr; n_fc = r_fc; n_lo = r_lo; n_fromstk = r_fromstk;
        n_job = r_job; n_lvl = r_lvl; n_plc = r_plc; n_idx = r_idx; n_cidx = r_cidx;
        n_s = r_s; n_nx = r_nx; n_pv = r_pv; n_chk = 1'b0; n_ret = r_ret;
        n_qty = r_qty; n_k = r_k;
        n_res = '0; n_stb = 1'b0;
        slot_ra = r_s; stk_ra = '0; lvl_ra = r_lvl;
        w_slot = r_s; w_valid = r_s; w_next = '0; w_prev = r_s; w_stk = r_fc[AW-1:0];
        w_lvl = r_lvl;
        we_id = 1'b0; we_rem = 1'b0; we_place = 1'b0; we_valid = 1'b0; we_next = 1'b0;
        we_prev = 1'b0; we_head = 1'b0; we_tail = 1'b0; we_stk = 1'b0;
        wd_rem = '0; wd_valid = 1'b0; wd_next = '0; wd_prev = '0; wd_stk = r_s;
        wd_head = NIL; wd_tail = NIL;
        unique case (r_state)
            B_CLEAR: begin
                n_clr   = r_clr + 1'b1;
                w_valid = r_clr[AW-1:0];
                w_lvl   = r_clr[LW-1:0];
                we_valid = (32'(r_clr) < 32'(MAX_ORDERS));
                we_head  = (32'(r_clr) < 32'(LV));
                we_tail  = we_head;
            end
            B_IDLE: begin
                if (i_job_vld) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_lvl = job_lvl;
                    n_idx = '0;
                    n_qty = i_job.quantity;
                    n_k   = '0;
                    n_ret = 1'b0;
                    if (i_job.op == JOB_ADD && (!i_job.price_ok || r_fc == '0)) begin
                        n_stb = 1'b1;
                        n_res.kind = KIND_ACK;
                        n_res.last = 1'b1;
                    end
                    if (i_job.op == JOB_CONSUME && !i_job.price_ok) begin
                        n_stb = 1'b1;
                        n_res.kind = KIND_DONE;
                        n_res.leftover = i_job.quantity;
                        n_res.lvl_empty = 1'b1;
                        n_res.last = 1'b1;
                    end
                end
            end
            B_SRCH: begin
                // one slot issued per cycle, compared in the next cycle
                slot_ra = r_idx[AW-1:0];
                if (r_idx < (AW+1)'(MAX_ORDERS)) begin
                    n_cidx = r_idx[AW-1:0];
                    n_chk  = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
                if (hit || miss) begin
                    n_chk = 1'b0;
                    n_s   = r_cidx;
                    if (r_job.op == JOB_ADD) begin
                        if (hit) begin
                            n_stb = 1'b1;
                            n_res.kind = KIND_ACK;
                            n_res.last = 1'b1;
                        end
                    end else if (miss) begin
                        n_stb = 1'b1;
                        n_res.kind = KIND_CANCEL;
                        n_res.last = 1'b1;
                    end
                end
            end
            B_ALLOC_RD: begin
                // stack entries below the low watermark were never overwritten
                stk_ra    = AW'(r_fc - 1'b1);
                n_fc      = r_fc - 1'b1;
                n_fromstk = ((r_fc - 1'b1) >= r_lo);
                if ((r_fc - 1'b1) < r_lo) n_lo = r_fc - 1'b1;
            end
            B_ADD_WR: begin
                w_slot = new_s; we_id = 1'b1; we_place = 1'b1; we_rem = 1'b1;
                wd_rem = r_job.quantity;
                w_valid = new_s; we_valid = 1'b1; wd_valid = 1'b1;
                w_lvl = r_lvl;
                we_tail = 1'b1; wd_tail = {1'b0, new_s};
                if (d_head == NIL) begin
                    we_head = 1'b1; wd_head = {1'b0, new_s};
                end else begin
                    w_next = d_tail[AW-1:0]; we_next = 1'b1; wd_next = new_s;
                    w_prev = new_s; we_prev = 1'b1; wd_prev = d_tail[AW-1:0];
                end
                n_stb = 1'b1;
                n_res.kind = KIND_ACK;
                n_res.ok = 1'b1;
                n_res.last = 1'b1;
            end
            B_REL_RD: begin
                slot_ra = r_s;
            end
            B_REL_LV: begin
                n_nx   = d_next;
                n_pv   = d_prev;
                n_plc  = d_place;
                lvl_ra = d_place;
            end
            B_REL_DO: begin
                w_lvl = r_plc;
                if ({1'b0, r_s} == d_head && {1'b0, r_s} == d_tail) begin
                    we_head = 1'b1; we_tail = 1'b1;
                end else if ({1'b0, r_s} == d_head) begin
                    we_head = 1'b1; wd_head = {1'b0, r_nx};
                end else if ({1'b0, r_s} == d_tail) begin
                    we_tail = 1'b1; wd_tail = {1'b0, r_pv};
                end else begin
                    w_next = r_pv; we_next = 1'b1; wd_next = r_nx;
                    w_prev = r_nx; we_prev = 1'b1; wd_prev = r_pv;
                end
                w_valid = r_s; we_valid = 1'b1;
                we_stk = 1'b1;
                n_fc = r_fc + 1'b1;
                if (!r_ret) begin
                    n_stb = 1'b1;
                    n_res.kind = KIND_CANCEL;
                    n_res.ok = 1'b1;
                    n_res.last = 1'b1;
                end
            end
            B_C_HD: begin
                lvl_ra = r_lvl;
            end
            B_C_CHK: begin
                slot_ra = d_head[AW-1:0];
                n_s = d_head[AW-1:0];
                if (stop) begin
                    n_stb = 1'b1;
                    n_res.kind = KIND_DONE;
                    n_res.leftover = r_qty;
                    n_res.lvl_empty = (d_head == NIL);
                    n_res.last = 1'b1;
                end
            end
            B_C_FILL: begin
                n_qty = r_qty - fill;
                n_k = r_k + 1'b1;
                w_slot = r_s; we_rem = 1'b1; wd_rem = d_rem - fill;
                n_ret = 1'b1;
                n_stb = 1'b1;
                n_res.kind = KIND_FILL;
                n_res.buy_id  = r_job.side ? d_id : r_job.ord_id;
                n_res.sell_id = r_job.side ? r_job.ord_id : d_id;
                n_res.fill_price = r_job.price;
                n_res.fill_quantity = fill;
            end
            default: begin
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (we_id) m_id[w_slot] <= r_job.ord_id;
        if (we_rem) m_rem[w_slot] <= wd_rem;
        if (we_place) m_place[w_slot] <= r_lvl;
        if (we_valid) m_valid[w_valid] <= wd_valid;
        if (we_next) m_next[w_next] <= wd_next;
        if (we_prev) m_prev[w_prev] <= wd_prev;
        if (we_head) m_head[w_lvl] <= wd_head;
        if (we_tail) m_tail[w_lvl] <= wd_tail;
        if (we_stk) m_stk[w_stk] <= wd_stk;
        d_id    <= m_id[slot_ra];
        d_rem   <= m_rem[slot_ra];
        d_place <= m_place[slot_ra];
        d_next  <= m_next[slot_ra];
        d_prev  <= m_prev[slot_ra];
        d_valid <= m_valid[slot_ra];
        d_head  <= m_head[lvl_ra];
        d_tail  <= m_tail[lvl_ra];
        d_stk   <= m_stk[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_fc    <= (AW+1)'(MAX_ORDERS);
            r_lo    <= (AW+1)'(MAX_ORDERS);
            r_stb   <= 1'b0;
            r_chk   <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_fc    <= n_fc;
            r_lo    <= n_lo;
            r_stb   <= n_stb;
            r_chk   <= n_chk;
            r_k     <= n_k;
        end
        r_fromstk <= n_fromstk;
        r_job  <= n_job;
        r_lvl  <= n_lvl;
        r_plc  <= n_plc;
        r_idx  <= n_idx;
        r_cidx <= n_cidx;
        r_s    <= n_s;
        r_nx   <= n_nx;
        r_pv   <= n_pv;
        r_ret  <= n_ret;
        r_qty  <= n_qty;
        r_res  <= n_res;
    end

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_pop)
        else $error("job taken during clearing pass");
    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= (AW+1)'(MAX_ORDERS))
        else $error("free count overflow");
    a_lo_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_fc)
        else $error("free stack watermark above free count");
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= 6'(FILLS_PER_CONSUME))
        else $error("fill count beyond cap");

endmodule

>>> hw/rtl/price_level_order_book.sv
// top level of the price level order book: front end, job queue and matching back end
// depends on plob_pkg, plob_front, plob_fifo, plob_back

// An add with an in-range price and a free slot, or a cancel, takes one id search over the slot
// store, one slot a cycle; a consume with an in-range price reads the level head, checks it and
// then fills, and releases the order when a fill empties it, with no search. After reset a
// clearing pass over the valid flags and level heads and tails runs before the first command is
// executed; commands are still queued meanwhile until busy rises. Results come at most one per
// cycle on o_strobe and cannot be held off; the last result of a command has last set.
module price_level_order_book import plob_pkg::*; #(
    parameter int MAX_ORDERS        = 1024,
    parameter int PRICE_TICKS       = 256,
    parameter int FILLS_PER_CONSUME = 63
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output t_result o_result,
    output logic    o_strobe
);

    logic push, full, pop, jvld;
    t_job fjob, qjob;

    plob_front #(.PRICE_TICKS(PRICE_TICKS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .i_full(full), .o_push(push), .o_job(fjob)
    );

    plob_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(fjob), .i_pop(pop),
        .o_full(full), .o_vld(jvld), .o_job(qjob)
    );

    plob_back #(
        .MAX_ORDERS(MAX_ORDERS), .PRICE_TICKS(PRICE_TICKS),
        .FILLS_PER_CONSUME(FILLS_PER_CONSUME)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_vld(jvld), .i_job(qjob), .o_pop(pop),
        .o_res(o_result), .o_stb(o_strobe)
    );

endmodule

>>> dv/tb_price_level_order_book.sv
// testbench for price_level_order_book: drives add, cancel and consume beats and checks results
// depends on plob_pkg and the price_level_order_book rtl
`timescale 1ns / 1ps

import plob_pkg::*;

class book_scoreboard;
    localparam int NSLOT = 1024;
    localparam int NIL = NSLOT;
    localparam int NLEVEL = 512;
    localparam int FILL_CAP = 63;

    bit [31:0] sl_id [NSLOT];
    bit [31:0] sl_rem [NSLOT];
    int sl_lvl [NSLOT];
    int sl_nxt [NSLOT];
    int sl_prv [NSLOT];
    bit sl_live [NSLOT];
    int lv_head [NLEVEL];
    int lv_tail [NLEVEL];
    int free_stack [NSLOT];
    int free_top;
    t_result pending [$];
    int errors;

    function new();
        for (int i = 0; i < NLEVEL; i++) begin
            lv_head[i] = NIL;
            lv_tail[i] = NIL;
        end
        for (int i = 0; i < NSLOT; i++) begin
            free_stack[i] = NSLOT - 1 - i;
            sl_live[i] = 0;
        end
        free_top = NSLOT;
        errors = 0;
    endfunction

    function int lookup(bit [31:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (sl_live[i] && sl_id[i] == id) return i;
        return NIL;
    endfunction

    function void unlink(int s);
        int p;
        p = sl_lvl[s];
        if (s == lv_head[p] && s == lv_tail[p]) begin
            lv_head[p] = NIL;
            lv_tail[p] = NIL;
        end else if (s == lv_head[p]) begin
            lv_head[p] = sl_nxt[s];
        end else if (s == lv_tail[p]) begin
            lv_tail[p] = sl_prv[s];
        end else begin
            sl_nxt[sl_prv[s]] = sl_nxt[s];
            sl_prv[sl_nxt[s]] = sl_prv[s];
        end
        sl_live[s] = 0;
        free_stack[free_top++] = s;
    endfunction

    function int resting();
        return NSLOT - free_top;
    endfunction

    function bit level_has(bit sd, bit [7:0] pr);
        return lv_head[sd * 256 + pr] != NIL;
    endfunction

    // works out every result of one accepted beat
    function void note_cmd(t_cmd c);
        t_result r;
        int s, p, k;
        bit [31:0] q, m;
        r = '0;
        r.last = 1'b1;
        if (c.opcode == OPC_ADD) begin
            r.kind = KIND_ACK;
            if (free_top > 0 && lookup(c.ord_id) == NIL) begin
                s = free_stack[--free_top];
                p = c.side * 256 + c.price;
                sl_id[s] = c.ord_id;
                sl_rem[s] = c.quantity;
                sl_lvl[s] = p;
                sl_live[s] = 1;
                if (lv_head[p] == NIL) lv_head[p] = s;
                else begin
                    sl_nxt[lv_tail[p]] = s;
                    sl_prv[s] = lv_tail[p];
                end
                lv_tail[p] = s;
                r.ok = 1'b1;
            end
            pending = {pending, r};
        end else if (c.opcode == OPC_CANCEL) begin
            r.kind = KIND_CANCEL;
            s = lookup(c.ord_id);
            if (s != NIL) begin
                unlink(s);
                r.ok = 1'b1;
            end
            pending = {pending, r};
        end else if (c.opcode == OPC_CONSUME) begin
            p = (c.side ^ 1'b1) * 256 + c.price;
            q = c.quantity;
            k = 0;
            while (q > 0 && lv_head[p] != NIL && k < FILL_CAP) begin
                s = lv_head[p];
                m = (q < sl_rem[s]) ? q : sl_rem[s];
                q -= m;
                sl_rem[s] -= m;
                r = '0;
                r.kind = KIND_FILL;
                r.buy_id = c.side ? sl_id[s] : c.ord_id;
                r.sell_id = c.side ? c.ord_id : sl_id[s];
                r.fill_price = c.price;
                r.fill_quantity = m;
                pending = {pending, r};
                k++;
                if (sl_rem[s] == 0) unlink(s);
            end
            r = '0;
            r.kind = KIND_DONE;
            r.leftover = q;
            r.lvl_empty = (lv_head[p] == NIL);
            r.last = 1'b1;
            pending = {pending, r};
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = pending[0];
        pending.delete(0);
        if (got.kind != want.kind || got.ok != want.ok || got.buy_id != want.buy_id ||
            got.sell_id != want.sell_id || got.fill_price != want.fill_price ||
            got.fill_quantity != want.fill_quantity || got.leftover != want.leftover ||
            got.lvl_empty != want.lvl_empty || got.last != want.last) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb_price_level_order_book;
    localparam logic [1:0] OPC_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    t_result o_result;
    logic o_strobe;

    book_scoreboard book;
    bit [31:0] id_pool [$];
    bit [31:0] next_id;

    price_level_order_book DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_result(o_result), .o_strobe(o_strobe)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk)
        if (i_rst_n && o_strobe) book.check_result(o_result);

    // start stays high between back-to-back beats and drops only for a gap
    task automatic send_beat(t_cmd c);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        book.note_cmd(c);
    endtask

    task automatic send_op(logic [1:0] op, bit sd, bit [31:0] id, bit [7:0] pr, bit [31:0] q);
        t_cmd c;
        c.opcode = op;
        c.side = sd;
        c.ord_id = id;
        c.price = pr;
        c.quantity = q;
        send_beat(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (book.pending.size() != 0) @(posedge i_clk);
    endtask

    function bit [31:0] fresh_id();
        next_id += $urandom_range(1, 1 << 20);
        return next_id;
    endfunction

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        bit [31:0] id;
        int pick;
        book = new();
        next_id = 32'd100;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicates, zero quantities, queue order, unknown opcode
        send_op(OPC_ADD, 1'b0, 32'h0, 8'd0, 32'hFFFF_FFFF);
        send_op(OPC_ADD, 1'b1, 32'hFFFF_FFFF, 8'd255, 32'd0);
        send_op(OPC_ADD, 1'b0, 32'h0, 8'd5, 32'd3);
        send_op(OPC_ADD, 1'b1, 32'h11, 8'd255, 32'd7);
        send_op(OPC_ADD, 1'b1, 32'h12, 8'd255, 32'd9);
        send_op(OPC_CONSUME, 1'b0, 32'hAAAA_5555, 8'd255, 32'd10);
        send_op(OPC_CONSUME, 1'b0, 32'h5555_AAAA, 8'd255, 32'hFFFF_FFFF);
        send_op(OPC_CONSUME, 1'b1, 32'h77, 8'd0, 32'd0);
        send_op(OPC_CONSUME, 1'b1, 32'h78, 8'd0, 32'hFFFF_FFFE);
        send_op(OPC_CONSUME, 1'b1, 32'h79, 8'd0, 32'd5);
        send_op(OPC_CANCEL, 1'b0, 32'h0, 8'd0, 32'd0);
        send_op(OPC_CANCEL, 1'b0, 32'h0, 8'd0, 32'd0);
        send_op(OPC_ADD, 1'b0, 32'h21, 8'd9, 32'd1);
        send_op(OPC_ADD, 1'b0, 32'h22, 8'd9, 32'd1);
        send_op(OPC_ADD, 1'b0, 32'h23, 8'd9, 32'd1);
        send_op(OPC_CANCEL, 1'b1, 32'h22, 8'd9, 32'd0);
        send_op(OPC_CONSUME, 1'b1, 32'h24, 8'd9, 32'd5);
        send_op(OPC_UNUSED, 1'b1, 32'h25, 8'd9, 32'd5);
        drain();

        // fill cap: 70 one-lot orders on one level, then one large consume and a reissue
        for (int i = 0; i < 70; i++) send_op(OPC_ADD, 1'b1, 32'h1000 + i, 8'd128, 32'd1);
        send_op(OPC_CONSUME, 1'b0, 32'h2000, 8'd128, 32'd100);
        send_op(OPC_CONSUME, 1'b0, 32'h2000, 8'd128, 32'd37);
        drain();

        // random: mostly adds and matches on a few busy levels, plus cancels and noise
        for (int n = 0; n < 380; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                id = ($urandom_range(0, 9) == 0 && id_pool.size() != 0) ?
                     id_pool[$urandom_range(0, id_pool.size() - 1)] :
                     (($urandom_range(0, 19) == 0) ? $urandom : fresh_id());
                id_pool = {id_pool, id};
                send_op(OPC_ADD, 1'($urandom_range(0, 1)), id,
                        8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                        $urandom_range(60, 63)),
                        ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200));
            end else if (pick < 65) begin
                id = (id_pool.size() != 0 && $urandom_range(0, 4) != 0) ?
                     id_pool[$urandom_range(0, id_pool.size() - 1)] : $urandom;
                send_op(OPC_CANCEL, 1'($urandom_range(0, 1)), id, 8'($urandom), $urandom);
            end else if (pick < 97) begin
                send_op(OPC_CONSUME, 1'($urandom_range(0, 1)), $urandom,
                        8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                        $urandom_range(60, 63)),
                        ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 600));
            end else begin
                send_op(OPC_UNUSED, 1'($urandom_range(0, 1)), $urandom, 8'($urandom),
                        $urandom);
            end
            // pause until all results have come
            if (n == 190) drain();
        end

        drain();
        repeat (3000) @(posedge i_clk);
        if (book.errors == 0 && book.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
